>>> rtl/ppt_pkg.sv
package ppt_pkg;

   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 23;

   localparam logic [CSR_IDX_W-1:0] REG_LOOKAHEAD = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_MIN_SPEED = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_MAX_SPEED = 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_CURV_GAIN = 3'd3;
   localparam logic [CSR_IDX_W-1:0] REG_POS_TOL   = 3'd4;
   localparam logic [CSR_IDX_W-1:0] REG_HEAD_TOL  = 3'd5;

   localparam logic [22:0] RST_LOOKAHEAD = 23'd3072;
   localparam logic [14:0] RST_MIN_SPEED = 15'd0;
   localparam logic [14:0] RST_MAX_SPEED = 15'd32512;
   localparam logic [15:0] RST_CURV_GAIN = 16'd256;
   localparam logic [22:0] RST_POS_TOL   = 23'd512;
   localparam logic [15:0] RST_HEAD_TOL  = 16'd1638;

   localparam logic signed [23:0] PI_Q16      = 24'sd205887;
   localparam logic signed [23:0] TWO_PI_Q16  = 24'sd411775;
   localparam logic signed [23:0] HALF_PI_Q16 = 24'sd102944;
   localparam logic signed [17:0] CORDIC_K    = 18'sd9949;
   localparam logic signed [17:0] SIN_ONE     = 18'sd16384;
   localparam logic signed [18:0] DRIVE_MAX   = 19'sd131071;
   localparam logic signed [18:0] DRIVE_MIN   = -19'sd131072;

   localparam logic [4:0] CORDIC_LAST = 5'd15;
   localparam logic [4:0] SQRT_LAST   = 5'd24;
   localparam logic [4:0] DIV_LAST    = 5'd14;

   localparam logic [1:0] ST_RUN    = 2'd0;
   localparam logic [1:0] ST_NEAR   = 2'd1;
   localparam logic [1:0] ST_GOAL   = 2'd2;
   localparam logic [1:0] ST_NOPATH = 2'd3;

   localparam logic [1:0] SEL_IDX  = 2'd0;
   localparam logic [1:0] SEL_LAST = 2'd1;
   localparam logic [1:0] SEL_TGT  = 2'd2;

   localparam logic [4:0] OP_NOP       = 5'd0;
   localparam logic [4:0] OP_LATCH     = 5'd1;
   localparam logic [4:0] OP_LOAD      = 5'd2;
   localparam logic [4:0] OP_R2        = 5'd3;
   localparam logic [4:0] OP_SRCH_INIT = 5'd4;
   localparam logic [4:0] OP_RD        = 5'd5;
   localparam logic [4:0] OP_DIFF      = 5'd6;
   localparam logic [4:0] OP_SQ_X      = 5'd7;
   localparam logic [4:0] OP_SQ_Y      = 5'd8;
   localparam logic [4:0] OP_SRCH_HIT  = 5'd9;
   localparam logic [4:0] OP_SRCH_MISS = 5'd10;
   localparam logic [4:0] OP_SRCH_NEXT = 5'd11;
   localparam logic [4:0] OP_T2        = 5'd12;
   localparam logic [4:0] OP_AT_INIT   = 5'd13;
   localparam logic [4:0] OP_AT_STEP   = 5'd14;
   localparam logic [4:0] OP_ERR       = 5'd15;
   localparam logic [4:0] OP_WRAP      = 5'd16;
   localparam logic [4:0] OP_SQ_INIT   = 5'd17;
   localparam logic [4:0] OP_SQ_STEP   = 5'd18;
   localparam logic [4:0] OP_SPD_MAX   = 5'd19;
   localparam logic [4:0] OP_SIN_INIT  = 5'd20;
   localparam logic [4:0] OP_SIN_STEP  = 5'd21;
   localparam logic [4:0] OP_NUM       = 5'd22;
   localparam logic [4:0] OP_DEN       = 5'd23;
   localparam logic [4:0] OP_DIV_STEP  = 5'd24;
   localparam logic [4:0] OP_CLAMP     = 5'd25;
   localparam logic [4:0] OP_OUT       = 5'd26;

   typedef struct packed {
      logic [4:0] op;
      logic [1:0] sel;
      logic [1:0] kind;
   } ppt_cmd_type;

   typedef struct packed {
      logic       is_pose;
      logic       count_zero;
      logic       hit;
      logic       idx_last;
      logic       goal;
      logic       wrap;
      logic       l_zero;
      logic       out_free;
      logic [4:0] step;
   } ppt_stat_type;

   // atan(2^-i) in Q.16
   function automatic logic signed [19:0] atan_q16(input logic [3:0] i);
      logic signed [19:0] v;
      case (i)
         4'd0:    v = 20'sd51472;
         4'd1:    v = 20'sd30385;
         4'd2:    v = 20'sd16055;
         4'd3:    v = 20'sd8150;
         4'd4:    v = 20'sd4091;
         4'd5:    v = 20'sd2047;
         4'd6:    v = 20'sd1024;
         4'd7:    v = 20'sd512;
         4'd8:    v = 20'sd256;
         4'd9:    v = 20'sd128;
         4'd10:   v = 20'sd64;
         4'd11:   v = 20'sd32;
         4'd12:   v = 20'sd16;
         4'd13:   v = 20'sd8;
         4'd14:   v = 20'sd4;
         default: v = 20'sd2;
      endcase
      return v;
   endfunction

endpackage

>>> rtl/ppt_req_if.sv
interface ppt_req_if;
   logic               valid;
   logic               ready;
   logic               req_type;
   logic               new_path;
   logic signed [23:0] pos_x;
   logic signed [23:0] pos_y;
   logic signed [17:0] heading;

   modport source (output valid, req_type, new_path, pos_x, pos_y, heading, input ready);
   modport sink (input valid, req_type, new_path, pos_x, pos_y, heading, output ready);
endinterface

>>> rtl/ppt_rsp_if.sv
interface ppt_rsp_if;
   logic               valid;
   logic               ready;
   logic signed [17:0] left_drive;
   logic signed [17:0] right_drive;
   logic [1:0]         status;

   modport source (output valid, left_drive, right_drive, status, input ready);
   modport sink (input valid, left_drive, right_drive, status, output ready);
endinterface

>>> rtl/ppt_datapath.sv
module ppt_datapath #(
   parameter int MAX_WAYPOINTS = 256
) (
   input  logic                              clock,
   input  logic                              reset,
   input  ppt_pkg::ppt_cmd_type              cmd,
   output ppt_pkg::ppt_stat_type             stat,
   input  logic                              in_type,
   input  logic                              in_new_path,
   input  logic signed [23:0]                in_pos_x,
   input  logic signed [23:0]                in_pos_y,
   input  logic signed [17:0]                in_heading,
   output logic                              out_valid,
   input  logic                              out_ready,
   output logic signed [17:0]                out_left,
   output logic signed [17:0]                out_right,
   output logic [1:0]                        out_status,
   input  logic                              csr_we,
   input  logic [ppt_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [ppt_pkg::CSR_DATA_W-1:0]    csr_wdata
);

   localparam int AW = (MAX_WAYPOINTS > 1) ? $clog2(MAX_WAYPOINTS) : 1;
   localparam int CW = $clog2(MAX_WAYPOINTS + 1);

   logic [22:0] rad_ff, ptol_ff;
   logic [14:0] minsp_ff, maxsp_ff;
   logic [15:0] gain_ff, htol_ff;

   logic [CW-1:0] count_ff;
   logic [AW-1:0] la_ff, idx_ff, tgt_ff, last_idx, rd_addr, wr_addr;
   logic          wr_en;

   logic               type_ff, newp_ff;
   logic signed [23:0] px_ff, py_ff;
   logic signed [17:0] ph_ff;

   logic [65:0] wp_mem [MAX_WAYPOINTS];
   logic [65:0] rd_ff;

   logic signed [24:0] dx_ff, dy_ff;
   logic signed [18:0] hd_ff;
   logic [18:0]        hd_abs;
   logic [49:0]        acc_ff, dl_ff;
   logic [45:0]        r2_ff, t2_ff;

   logic signed [27:0] cx_ff, cy_ff;
   logic signed [19:0] az_ff;
   logic signed [23:0] err_ff, a_abs, a_fold;

   logic [49:0] sv_ff, sb_ff;
   logic [50:0] sr_ff, sq_t;
   logic [24:0] len;

   logic signed [17:0] sx_ff, sy_ff;
   logic signed [19:0] sz_ff;
   logic [14:0]        sin_s;

   logic [53:0] rem_ff, d_ff;
   logic [14:0] q_ff, spd_ff, spd_lo;
   logic [39:0] den;
   logic [4:0]  cnt_ff;

   logic signed [25:0] mul_a, mul_b;
   logic signed [51:0] prod;

   logic signed [24:0] e50;
   logic signed [16:0] ang;
   logic signed [19:0] sum_l, sum_r;
   logic signed [17:0] sat_l, sat_r;

   logic               ov_ff;
   logic signed [17:0] lft_ff, rgt_ff;
   logic [1:0]         st_ff;

   assign last_idx = AW'(count_ff - CW'(1));
   assign len      = sr_ff[24:0];
   assign hd_abs   = hd_ff[18] ? 19'(-hd_ff) : 19'(hd_ff);

   always_comb begin
      case (cmd.sel)
         ppt_pkg::SEL_LAST: rd_addr = last_idx;
         ppt_pkg::SEL_TGT:  rd_addr = tgt_ff;
         default:           rd_addr = idx_ff;
      endcase
   end

   assign wr_addr = newp_ff ? '0 : count_ff[AW-1:0];
   assign wr_en   = (cmd.op == ppt_pkg::OP_LOAD) &&
                    (newp_ff || (count_ff < CW'(MAX_WAYPOINTS)));

   always_ff @(posedge clock) begin
      if (wr_en) begin
         wp_mem[wr_addr] <= {px_ff, py_ff, ph_ff};
      end
      if (cmd.op == ppt_pkg::OP_RD) begin
         rd_ff <= wp_mem[rd_addr];
      end
   end

   // shared multiplier
   always_comb begin
      case (cmd.op)
         ppt_pkg::OP_SQ_X: begin
            mul_a = 26'(dx_ff);
            mul_b = 26'(dx_ff);
         end
         ppt_pkg::OP_SQ_Y: begin
            mul_a = 26'(dy_ff);
            mul_b = 26'(dy_ff);
         end
         ppt_pkg::OP_R2: begin
            mul_a = {3'b0, rad_ff};
            mul_b = {3'b0, rad_ff};
         end
         ppt_pkg::OP_T2: begin
            mul_a = {3'b0, ptol_ff};
            mul_b = {3'b0, ptol_ff};
         end
         ppt_pkg::OP_NUM: begin
            mul_a = {11'b0, maxsp_ff};
            mul_b = {1'b0, len};
         end
         ppt_pkg::OP_DEN: begin
            mul_a = {10'b0, gain_ff};
            mul_b = {11'b0, sin_s};
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end
   assign prod = mul_a * mul_b;

   assign sq_t   = sr_ff + {1'b0, sb_ff};
   assign a_abs  = err_ff[23] ? -err_ff : err_ff;
   assign a_fold = (a_abs > ppt_pkg::HALF_PI_Q16) ? (ppt_pkg::PI_Q16 - a_abs) : a_abs;
   assign sin_s  = (sy_ff < 18'sd0) ? 15'd0 :
                   (sy_ff > ppt_pkg::SIN_ONE) ? 15'(ppt_pkg::SIN_ONE) : sy_ff[14:0];
   assign den    = {1'b0, len, 14'b0} + {8'b0, prod[30:0], 1'b0};
   assign spd_lo = (q_ff < minsp_ff) ? minsp_ff : q_ff;

   assign e50   = (25'($signed(err_ff[18:0])) <<< 5) + (25'($signed(err_ff[18:0])) <<< 4) +
                  (25'($signed(err_ff[18:0])) <<< 1);
   assign ang   = e50[24:8];
   assign sum_l = $signed({5'b0, spd_ff}) + 20'(ang);
   assign sum_r = $signed({5'b0, spd_ff}) - 20'(ang);
   assign sat_l = (sum_l > 20'(ppt_pkg::DRIVE_MAX)) ? 18'(ppt_pkg::DRIVE_MAX) :
                  (sum_l < 20'(ppt_pkg::DRIVE_MIN)) ? 18'(ppt_pkg::DRIVE_MIN) : sum_l[17:0];
   assign sat_r = (sum_r > 20'(ppt_pkg::DRIVE_MAX)) ? 18'(ppt_pkg::DRIVE_MAX) :
                  (sum_r < 20'(ppt_pkg::DRIVE_MIN)) ? 18'(ppt_pkg::DRIVE_MIN) : sum_r[17:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         rad_ff   <= ppt_pkg::RST_LOOKAHEAD;
         minsp_ff <= ppt_pkg::RST_MIN_SPEED;
         maxsp_ff <= ppt_pkg::RST_MAX_SPEED;
         gain_ff  <= ppt_pkg::RST_CURV_GAIN;
         ptol_ff  <= ppt_pkg::RST_POS_TOL;
         htol_ff  <= ppt_pkg::RST_HEAD_TOL;
      end else if (csr_we) begin
         case (csr_index)
            ppt_pkg::REG_LOOKAHEAD: rad_ff   <= csr_wdata[22:0];
            ppt_pkg::REG_MIN_SPEED: minsp_ff <= csr_wdata[14:0];
            ppt_pkg::REG_MAX_SPEED: maxsp_ff <= csr_wdata[14:0];
            ppt_pkg::REG_CURV_GAIN: gain_ff  <= csr_wdata[15:0];
            ppt_pkg::REG_POS_TOL:   ptol_ff  <= csr_wdata[22:0];
            ppt_pkg::REG_HEAD_TOL:  htol_ff  <= csr_wdata[15:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         la_ff    <= '0;
         ov_ff    <= 1'b0;
      end else begin
         if (ov_ff && out_ready && (cmd.op != ppt_pkg::OP_OUT)) begin
            ov_ff <= 1'b0;
         end
         case (cmd.op)
            ppt_pkg::OP_LATCH: begin
               type_ff <= in_type;
               newp_ff <= in_new_path;
               px_ff   <= in_pos_x;
               py_ff   <= in_pos_y;
               ph_ff   <= in_heading;
            end
            ppt_pkg::OP_LOAD: begin
               if (newp_ff) begin
                  count_ff <= CW'(1);
                  la_ff    <= '0;
               end else if (wr_en) begin
                  count_ff <= count_ff + CW'(1);
               end
            end
            ppt_pkg::OP_R2:        r2_ff <= prod[45:0];
            ppt_pkg::OP_SRCH_INIT: idx_ff <= la_ff;
            ppt_pkg::OP_DIFF: begin
               dx_ff <= 25'($signed(rd_ff[65:42])) - 25'(px_ff);
               dy_ff <= 25'($signed(rd_ff[41:18])) - 25'(py_ff);
               hd_ff <= 19'(ph_ff) - 19'($signed(rd_ff[17:0]));
            end
            ppt_pkg::OP_SQ_X:      acc_ff <= prod[49:0];
            ppt_pkg::OP_SQ_Y:      acc_ff <= acc_ff + prod[49:0];
            ppt_pkg::OP_SRCH_HIT: begin
               la_ff  <= idx_ff;
               tgt_ff <= idx_ff;
            end
            ppt_pkg::OP_SRCH_MISS: tgt_ff <= last_idx;
            ppt_pkg::OP_SRCH_NEXT: idx_ff <= idx_ff + AW'(1);
            ppt_pkg::OP_T2: begin
               t2_ff <= prod[45:0];
               dl_ff <= acc_ff;
            end
            ppt_pkg::OP_AT_INIT: begin
               cnt_ff <= '0;
               if (dx_ff < 25'sd0) begin
                  cx_ff <= -28'(dx_ff);
                  cy_ff <= -28'(dy_ff);
                  az_ff <= (dy_ff >= 25'sd0) ? 20'(ppt_pkg::PI_Q16) : -20'(ppt_pkg::PI_Q16);
               end else begin
                  cx_ff <= 28'(dx_ff);
                  cy_ff <= 28'(dy_ff);
                  az_ff <= '0;
               end
            end
            ppt_pkg::OP_AT_STEP: begin
               cnt_ff <= cnt_ff + 5'd1;
               if (cy_ff > 28'sd0) begin
                  cx_ff <= cx_ff + (cy_ff >>> cnt_ff);
                  cy_ff <= cy_ff - (cx_ff >>> cnt_ff);
                  az_ff <= az_ff + ppt_pkg::atan_q16(cnt_ff[3:0]);
               end else if (cy_ff < 28'sd0) begin
                  cx_ff <= cx_ff - (cy_ff >>> cnt_ff);
                  cy_ff <= cy_ff + (cx_ff >>> cnt_ff);
                  az_ff <= az_ff - ppt_pkg::atan_q16(cnt_ff[3:0]);
               end
            end
            ppt_pkg::OP_ERR: err_ff <= 24'(az_ff) - (24'(ph_ff) <<< 4);
            ppt_pkg::OP_WRAP: begin
               if (err_ff > ppt_pkg::PI_Q16) begin
                  err_ff <= err_ff - ppt_pkg::TWO_PI_Q16;
               end else begin
                  err_ff <= err_ff + ppt_pkg::TWO_PI_Q16;
               end
            end
            ppt_pkg::OP_SQ_INIT: begin
               cnt_ff <= '0;
               sv_ff  <= acc_ff;
               sr_ff  <= '0;
               sb_ff  <= 50'(1) << 48;
            end
            ppt_pkg::OP_SQ_STEP: begin
               cnt_ff <= cnt_ff + 5'd1;
               sb_ff  <= sb_ff >> 2;
               if ({1'b0, sv_ff} >= sq_t) begin
                  sv_ff <= sv_ff - sq_t[49:0];
                  sr_ff <= (sr_ff >> 1) + {1'b0, sb_ff};
               end else begin
                  sr_ff <= sr_ff >> 1;
               end
            end
            ppt_pkg::OP_SPD_MAX: spd_ff <= maxsp_ff;
            ppt_pkg::OP_SIN_INIT: begin
               cnt_ff <= '0;
               sx_ff  <= ppt_pkg::CORDIC_K;
               sy_ff  <= '0;
               sz_ff  <= a_fold[19:0];
            end
            ppt_pkg::OP_SIN_STEP: begin
               cnt_ff <= cnt_ff + 5'd1;
               if (sz_ff >= 20'sd0) begin
                  sx_ff <= sx_ff - (sy_ff >>> cnt_ff);
                  sy_ff <= sy_ff + (sx_ff >>> cnt_ff);
                  sz_ff <= sz_ff - ppt_pkg::atan_q16(cnt_ff[3:0]);
               end else begin
                  sx_ff <= sx_ff + (sy_ff >>> cnt_ff);
                  sy_ff <= sy_ff - (sx_ff >>> cnt_ff);
                  sz_ff <= sz_ff + ppt_pkg::atan_q16(cnt_ff[3:0]);
               end
            end
            ppt_pkg::OP_NUM: rem_ff <= {prod[39:0], 14'b0};
            ppt_pkg::OP_DEN: begin
               d_ff   <= {den, 14'b0};
               q_ff   <= '0;
               cnt_ff <= '0;
            end
            ppt_pkg::OP_DIV_STEP: begin
               cnt_ff <= cnt_ff + 5'd1;
               d_ff   <= d_ff >> 1;
               if (rem_ff >= d_ff) begin
                  rem_ff <= rem_ff - d_ff;
                  q_ff   <= {q_ff[13:0], 1'b1};
               end else begin
                  q_ff   <= {q_ff[13:0], 1'b0};
               end
            end
            ppt_pkg::OP_CLAMP: spd_ff <= (spd_lo > maxsp_ff) ? maxsp_ff : spd_lo;
            ppt_pkg::OP_OUT: begin
               ov_ff <= 1'b1;
               if (cmd.kind == ppt_pkg::ST_RUN) begin
                  lft_ff <= sat_l;
                  rgt_ff <= sat_r;
                  st_ff  <= (dl_ff < {4'b0, r2_ff}) ? ppt_pkg::ST_NEAR : ppt_pkg::ST_RUN;
               end else begin
                  lft_ff <= '0;
                  rgt_ff <= '0;
                  st_ff  <= cmd.kind;
               end
            end
            default: ;
         endcase
      end
   end

   always_comb begin
      stat.is_pose    = type_ff;
      stat.count_zero = (count_ff == '0);
      stat.hit        = (acc_ff >= {4'b0, r2_ff});
      stat.idx_last   = (idx_ff == last_idx);
      stat.goal       = (dl_ff < {4'b0, t2_ff}) && (hd_abs < {3'b0, htol_ff});
      stat.wrap       = (err_ff > ppt_pkg::PI_Q16) || (err_ff < -ppt_pkg::PI_Q16);
      stat.l_zero     = (sr_ff == '0);
      stat.out_free   = !ov_ff || out_ready;
      stat.step       = cnt_ff;
   end

   assign out_valid  = ov_ff;
   assign out_left   = lft_ff;
   assign out_right  = rgt_ff;
   assign out_status = st_ff;

endmodule

>>> rtl/ppt_ctrl.sv
module ppt_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  ppt_pkg::ppt_stat_type stat,
   output ppt_pkg::ppt_cmd_type  cmd
);

   localparam logic [4:0] S_IDLE  = 5'd0;
   localparam logic [4:0] S_DISP  = 5'd1;
   localparam logic [4:0] S_SINIT = 5'd2;
   localparam logic [4:0] S_RD    = 5'd3;
   localparam logic [4:0] S_DIFF  = 5'd4;
   localparam logic [4:0] S_SQX   = 5'd5;
   localparam logic [4:0] S_SQY   = 5'd6;
   localparam logic [4:0] S_SCMP  = 5'd7;
   localparam logic [4:0] S_T2    = 5'd8;
   localparam logic [4:0] S_GOAL  = 5'd9;
   localparam logic [4:0] S_ATI   = 5'd10;
   localparam logic [4:0] S_ATS   = 5'd11;
   localparam logic [4:0] S_ERR   = 5'd12;
   localparam logic [4:0] S_WRAP  = 5'd13;
   localparam logic [4:0] S_SQI   = 5'd14;
   localparam logic [4:0] S_SQS   = 5'd15;
   localparam logic [4:0] S_LZ    = 5'd16;
   localparam logic [4:0] S_SINI  = 5'd17;
   localparam logic [4:0] S_SINS  = 5'd18;
   localparam logic [4:0] S_NUM   = 5'd19;
   localparam logic [4:0] S_DEN   = 5'd20;
   localparam logic [4:0] S_DIV   = 5'd21;
   localparam logic [4:0] S_CLAMP = 5'd22;
   localparam logic [4:0] S_EMIT  = 5'd23;

   logic [4:0] state_ff, state_in;
   logic [1:0] phase_ff, phase_in;
   logic [1:0] kind_ff, kind_in;

   always_comb begin
      state_in  = state_ff;
      phase_in  = phase_ff;
      kind_in   = kind_ff;
      req_ready = 1'b0;
      cmd.op    = ppt_pkg::OP_NOP;
      cmd.sel   = phase_ff;
      cmd.kind  = kind_ff;
      case (state_ff)
         S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.op   = ppt_pkg::OP_LATCH;
               state_in = S_DISP;
            end
         end
         S_DISP: begin
            if (!stat.is_pose) begin
               cmd.op   = ppt_pkg::OP_LOAD;
               state_in = S_IDLE;
            end else if (stat.count_zero) begin
               kind_in  = ppt_pkg::ST_NOPATH;
               state_in = S_EMIT;
            end else begin
               cmd.op   = ppt_pkg::OP_R2;
               state_in = S_SINIT;
            end
         end
         S_SINIT: begin
            cmd.op   = ppt_pkg::OP_SRCH_INIT;
            phase_in = ppt_pkg::SEL_IDX;
            state_in = S_RD;
         end
         S_RD: begin
            cmd.op   = ppt_pkg::OP_RD;
            state_in = S_DIFF;
         end
         S_DIFF: begin
            cmd.op   = ppt_pkg::OP_DIFF;
            state_in = S_SQX;
         end
         S_SQX: begin
            cmd.op   = ppt_pkg::OP_SQ_X;
            state_in = S_SQY;
         end
         S_SQY: begin
            cmd.op = ppt_pkg::OP_SQ_Y;
            case (phase_ff)
               ppt_pkg::SEL_IDX:  state_in = S_SCMP;
               ppt_pkg::SEL_LAST: state_in = S_T2;
               default:           state_in = S_ATI;
            endcase
         end
         S_SCMP: begin
            state_in = S_RD;
            if (stat.hit) begin
               cmd.op   = ppt_pkg::OP_SRCH_HIT;
               phase_in = ppt_pkg::SEL_LAST;
            end else if (stat.idx_last) begin
               cmd.op   = ppt_pkg::OP_SRCH_MISS;
               phase_in = ppt_pkg::SEL_LAST;
            end else begin
               cmd.op   = ppt_pkg::OP_SRCH_NEXT;
            end
         end
         S_T2: begin
            cmd.op   = ppt_pkg::OP_T2;
            state_in = S_GOAL;
         end
         S_GOAL: begin
            if (stat.goal) begin
               kind_in  = ppt_pkg::ST_GOAL;
               state_in = S_EMIT;
            end else begin
               phase_in = ppt_pkg::SEL_TGT;
               state_in = S_RD;
            end
         end
         S_ATI: begin
            cmd.op   = ppt_pkg::OP_AT_INIT;
            state_in = S_ATS;
         end
         S_ATS: begin
            cmd.op = ppt_pkg::OP_AT_STEP;
            if (stat.step == ppt_pkg::CORDIC_LAST) begin
               state_in = S_ERR;
            end
         end
         S_ERR: begin
            cmd.op   = ppt_pkg::OP_ERR;
            state_in = S_WRAP;
         end
         S_WRAP: begin
            if (stat.wrap) begin
               cmd.op = ppt_pkg::OP_WRAP;
            end else begin
               state_in = S_SQI;
            end
         end
         S_SQI: begin
            cmd.op   = ppt_pkg::OP_SQ_INIT;
            state_in = S_SQS;
         end
         S_SQS: begin
            cmd.op = ppt_pkg::OP_SQ_STEP;
            if (stat.step == ppt_pkg::SQRT_LAST) begin
               state_in = S_LZ;
            end
         end
         S_LZ: begin
            kind_in = ppt_pkg::ST_RUN;
            if (stat.l_zero) begin
               cmd.op   = ppt_pkg::OP_SPD_MAX;
               state_in = S_EMIT;
            end else begin
               state_in = S_SINI;
            end
         end
         S_SINI: begin
            cmd.op   = ppt_pkg::OP_SIN_INIT;
            state_in = S_SINS;
         end
         S_SINS: begin
            cmd.op = ppt_pkg::OP_SIN_STEP;
            if (stat.step == ppt_pkg::CORDIC_LAST) begin
               state_in = S_NUM;
            end
         end
         S_NUM: begin
            cmd.op   = ppt_pkg::OP_NUM;
            state_in = S_DEN;
         end
         S_DEN: begin
            cmd.op   = ppt_pkg::OP_DEN;
            state_in = S_DIV;
         end
         S_DIV: begin
            cmd.op = ppt_pkg::OP_DIV_STEP;
            if (stat.step == ppt_pkg::DIV_LAST) begin
               state_in = S_CLAMP;
            end
         end
         S_CLAMP: begin
            cmd.op   = ppt_pkg::OP_CLAMP;
            state_in = S_EMIT;
         end
         S_EMIT: begin
            if (stat.out_free) begin
               cmd.op   = ppt_pkg::OP_OUT;
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         phase_ff <= ppt_pkg::SEL_IDX;
         kind_ff  <= ppt_pkg::ST_RUN;
      end else begin
         state_ff <= state_in;
         phase_ff <= phase_in;
         kind_ff  <= kind_in;
      end
   end

endmodule

>>> rtl/pure_pursuit_path_tracker_unit.sv
// Waypoint request: latched, then stored, then the next request is taken.
// Control request: lookahead search over the waypoints through one shared
// multiplier (each visited waypoint is read, differenced, squared and compared),
// goal check, atan2 CORDIC, angle wrap steps, sqrt, sin CORDIC, division, clamp.
// Results wait in an output register; the next request is taken meanwhile.
// Synchronous active-high reset: empty path, lookahead index 0, registers default.
module pure_pursuit_path_tracker_unit #(
   parameter int MAX_WAYPOINTS = 256
) (
   input  logic                           clock,
   input  logic                           reset,
   ppt_req_if.sink                        req_bus,
   ppt_rsp_if.source                      rsp_bus,
   input  logic                           csr_we,
   input  logic [ppt_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [ppt_pkg::CSR_DATA_W-1:0] csr_wdata
);

   ppt_pkg::ppt_cmd_type  cmd;
   ppt_pkg::ppt_stat_type stat;

   ppt_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_bus.valid),
      .req_ready (req_bus.ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   ppt_datapath #(
      .MAX_WAYPOINTS (MAX_WAYPOINTS)
   ) u_dp (
      .clock       (clock),
      .reset       (reset),
      .cmd         (cmd),
      .stat        (stat),
      .in_type     (req_bus.req_type),
      .in_new_path (req_bus.new_path),
      .in_pos_x    (req_bus.pos_x),
      .in_pos_y    (req_bus.pos_y),
      .in_heading  (req_bus.heading),
      .out_valid   (rsp_bus.valid),
      .out_ready   (rsp_bus.ready),
      .out_left    (rsp_bus.left_drive),
      .out_right   (rsp_bus.right_drive),
      .out_status  (rsp_bus.status),
      .csr_we      (csr_we),
      .csr_index   (csr_index),
      .csr_wdata   (csr_wdata)
   );

endmodule

>>> bench/pure_pursuit_path_tracker_unit_tb.sv
module pure_pursuit_path_tracker_unit_tb;

   localparam int DEPTH       = 256;
   localparam int CYCLE_LIMIT = 4000000;
   localparam longint PI_V     = 205887;
   localparam longint TWO_PI_V = 411775;
   localparam longint HALF_PI_V = 102944;
   localparam logic [ppt_pkg::CSR_IDX_W-1:0] REG_UNLISTED = 3'd7;

   typedef struct {
      logic signed [17:0] left_drive;
      logic signed [17:0] right_drive;
      logic [1:0]         status;
   } drive_cmd_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic csr_we = 1'b0;
   logic [ppt_pkg::CSR_IDX_W-1:0]  csr_index = '0;
   logic [ppt_pkg::CSR_DATA_W-1:0] csr_wdata = '0;

   ppt_req_if req_bus ();
   ppt_rsp_if rsp_bus ();

   pure_pursuit_path_tracker_unit #(.MAX_WAYPOINTS(DEPTH)) u_dut (
      .clock(clock), .reset(reset), .req_bus(req_bus), .rsp_bus(rsp_bus),
      .csr_we(csr_we), .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   // predictor state
   longint wp_x [DEPTH];
   longint wp_y [DEPTH];
   longint wp_h [DEPTH];
   int     wp_count;
   int     la_index;
   longint r_look, r_min, r_max, r_gain, r_ptol, r_htol;

   drive_cmd_type expected_drive_q[$];
   int  fail_count = 0;
   int  cycle_count = 0;
   bit  burst_mode = 1'b0;
   int  burst_left = 0;
   longint atan_lut [16] = '{51472, 30385, 16055, 8150, 4091, 2047, 1024, 512,
                             256, 128, 64, 32, 16, 8, 4, 2};

   initial begin
      forever #1 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Regression FAIL");
         $finish;
      end
   end

   function automatic longint floor_shift(longint v, int s);
      if (v >= 0) return v >>> s;
      return -((-(v + 1)) >>> s) - 1;
   endfunction

   function automatic longint int_sqrt(longint unsigned v);
      longint unsigned r, b;
      r = 0;
      b = 64'd1 << 62;
      while (b > v) b = b >> 2;
      while (b != 0) begin
         if (v >= r + b) begin
            v = v - (r + b);
            r = (r >> 1) + b;
         end else begin
            r = r >> 1;
         end
         b = b >> 2;
      end
      return longint'(r);
   endfunction

   function automatic longint bearing_q16(longint y, longint x);
      longint base, z, nx, ny;
      base = 0;
      z = 0;
      if (x < 0) begin
         base = (y >= 0) ? PI_V : -PI_V;
         x = -x;
         y = -y;
      end
      for (int i = 0; i < 16; i++) begin
         nx = x;
         ny = y;
         if (y > 0) begin
            nx = x + floor_shift(y, i);
            ny = y - floor_shift(x, i);
            z += atan_lut[i];
         end else if (y < 0) begin
            nx = x - floor_shift(y, i);
            ny = y + floor_shift(x, i);
            z -= atan_lut[i];
         end
         x = nx;
         y = ny;
      end
      return base + z;
   endfunction

   function automatic longint abs_sine_q14(longint a);
      longint x, y, z, nx, ny;
      x = 9949;
      y = 0;
      if (a > HALF_PI_V) a = PI_V - a;
      z = a;
      for (int i = 0; i < 16; i++) begin
         if (z >= 0) begin
            nx = x - floor_shift(y, i);
            ny = y + floor_shift(x, i);
            z -= atan_lut[i];
         end else begin
            nx = x + floor_shift(y, i);
            ny = y - floor_shift(x, i);
            z += atan_lut[i];
         end
         x = nx;
         y = ny;
      end
      if (y < 0) y = 0;
      if (y > 16384) y = 16384;
      return y;
   endfunction

   function automatic longint sq_dist(longint ax, longint ay, longint bx, longint by);
      return (bx - ax) * (bx - ax) + (by - ay) * (by - ay);
   endfunction

   function automatic longint sat18(longint v);
      if (v > 131071) return 131071;
      if (v < -131072) return -131072;
      return v;
   endfunction

   function automatic void predict_tracker(logic rtype, logic newp, longint px, longint py,
                                           longint ph);
      drive_cmd_type d;
      longint r2, dx, dy, err, hdiff, speed, ang, s, lq, den, dl;
      int tgt, last;
      if (!rtype) begin
         if (newp) begin
            wp_count = 0;
            la_index = 0;
         end
         if (wp_count < DEPTH) begin
            wp_x[wp_count] = px;
            wp_y[wp_count] = py;
            wp_h[wp_count] = ph;
            wp_count++;
         end
         return;
      end
      if (wp_count == 0) begin
         d.left_drive = '0;
         d.right_drive = '0;
         d.status = ppt_pkg::ST_NOPATH;
         expected_drive_q.push_back(d);
         return;
      end
      r2 = r_look * r_look;
      last = wp_count - 1;
      tgt = last;
      for (int i = la_index; i < wp_count; i++) begin
         if (sq_dist(px, py, wp_x[i], wp_y[i]) >= r2) begin
            la_index = i;
            tgt = i;
            break;
         end
      end
      hdiff = ph - wp_h[last];
      if (hdiff < 0) hdiff = -hdiff;
      dl = sq_dist(px, py, wp_x[last], wp_y[last]);
      if (dl < r_ptol * r_ptol && hdiff < r_htol) begin
         d.left_drive = '0;
         d.right_drive = '0;
         d.status = ppt_pkg::ST_GOAL;
         expected_drive_q.push_back(d);
         return;
      end
      dx = wp_x[tgt] - px;
      dy = wp_y[tgt] - py;
      err = bearing_q16(dy, dx) - ph * 16;
      while (err > PI_V) err -= TWO_PI_V;
      while (err < -PI_V) err += TWO_PI_V;
      lq = int_sqrt(longint'(dx * dx + dy * dy));
      if (lq == 0) begin
         speed = r_max;
      end else begin
         s = abs_sine_q14(err < 0 ? -err : err);
         lq = lq * 16384;
         den = lq + 2 * r_gain * s;
         speed = (r_max * lq) / den;
      end
      if (speed < r_min) speed = r_min;
      if (speed > r_max) speed = r_max;
      ang = floor_shift(err * 50, 8);
      d.left_drive = 18'(sat18(speed + ang));
      d.right_drive = 18'(sat18(speed - ang));
      d.status = (dl < r2) ? ppt_pkg::ST_NEAR : ppt_pkg::ST_RUN;
      expected_drive_q.push_back(d);
   endfunction

   // receiver: stall pattern, check at the rising edge
   always @(posedge clock) begin
      drive_cmd_type e;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         if (expected_drive_q.size() == 0) begin
            $error("unexpected drive result");
            fail_count++;
         end else begin
            e = expected_drive_q.pop_front();
            if (rsp_bus.left_drive !== e.left_drive) begin
               $error("left_drive exp %0d got %0d", e.left_drive, rsp_bus.left_drive);
               fail_count++;
            end
            if (rsp_bus.right_drive !== e.right_drive) begin
               $error("right_drive exp %0d got %0d", e.right_drive, rsp_bus.right_drive);
               fail_count++;
            end
            if (rsp_bus.status !== e.status) begin
               $error("status exp %0d got %0d", e.status, rsp_bus.status);
               fail_count++;
            end
         end
      end
   end

   always @(negedge clock) begin
      if ((cycle_count / 300) % 4 == 0) rsp_bus.ready <= 1'b1;
      else rsp_bus.ready <= ($urandom_range(0, 9) < 6);
   end

   task automatic write_reg(logic [ppt_pkg::CSR_IDX_W-1:0] idx, longint unsigned val);
      @(negedge clock);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val[ppt_pkg::CSR_DATA_W-1:0];
      @(negedge clock);
      csr_we <= 1'b0;
      case (idx)
         ppt_pkg::REG_LOOKAHEAD: r_look = val & 64'h7FFFFF;
         ppt_pkg::REG_MIN_SPEED: r_min = val & 64'h7FFF;
         ppt_pkg::REG_MAX_SPEED: r_max = val & 64'h7FFF;
         ppt_pkg::REG_CURV_GAIN: r_gain = val & 64'hFFFF;
         ppt_pkg::REG_POS_TOL:   r_ptol = val & 64'h7FFFFF;
         ppt_pkg::REG_HEAD_TOL:  r_htol = val & 64'hFFFF;
         default: ;
      endcase
   endtask

   task automatic wait_drain();
      while (expected_drive_q.size() != 0) @(posedge clock);
      repeat (200 + 5 * DEPTH) @(posedge clock);
   endtask

   task automatic send_item(logic rtype, logic newp, logic signed [23:0] px,
                            logic signed [23:0] py, logic signed [17:0] ph);
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 20);
         if (burst_mode) begin
            @(negedge clock);
            req_bus.valid <= 1'b0;
            repeat ($urandom_range(0, 12)) @(negedge clock);
         end
      end
      burst_left--;
      @(negedge clock);
      req_bus.valid <= 1'b1;
      req_bus.req_type <= rtype;
      req_bus.new_path <= newp;
      req_bus.pos_x <= px;
      req_bus.pos_y <= py;
      req_bus.heading <= ph;
      do @(posedge clock); while (!req_bus.ready);
      predict_tracker(rtype, newp, longint'(px), longint'(py), longint'(ph));
      @(negedge clock);
      req_bus.valid <= 1'b0;
   endtask

   function automatic logic signed [23:0] rand_pos(int span);
      int v;
      case ($urandom_range(0, 9))
         0: return 24'sh7FFFFF;
         1: return -24'sh800000;
         2: return 24'($urandom);
         default: begin
            v = $urandom_range(0, 2 * span) - span;
            return 24'(v);
         end
      endcase
   endfunction

   task automatic test_empty_path();
      send_item(1'b1, 1'b0, 24'sd100, -24'sd100, 18'sd0);
      send_item(1'b1, 1'b1, 24'sh7FFFFF, -24'sh800000, 18'sh1FFFF);
      wait_drain();
   endtask

   task automatic test_directed();
      send_item(1'b0, 1'b1, 24'sd0, 24'sd0, 18'sd0);
      send_item(1'b1, 1'b0, 24'sd0, 24'sd0, 18'sd0);
      send_item(1'b1, 1'b0, 24'sd100, 24'sd0, 18'sd100);
      send_item(1'b0, 1'b0, 24'sd4096, 24'sd0, 18'sd0);
      send_item(1'b0, 1'b0, 24'sd8192, 24'sd4096, 18'sd6434);
      send_item(1'b1, 1'b0, -24'sd2000, 24'sd50, -18'sd20000);
      send_item(1'b1, 1'b1, -24'sd9000, -24'sd3000, 18'sh1FFFF);
      send_item(1'b1, 1'b0, 24'sd8192, 24'sd4096, 18'sd6434);
      send_item(1'b1, 1'b0, 24'sd8192, 24'sd4000, -18'sh20000);
      send_item(1'b0, 1'b1, 24'sh7FFFFF, 24'sh7FFFFF, 18'sh1FFFF);
      send_item(1'b0, 1'b0, -24'sh800000, -24'sh800000, -18'sh20000);
      send_item(1'b1, 1'b0, 24'sh7FFFFF, -24'sh800000, 18'sd0);
      send_item(1'b1, 1'b0, -24'sh800000, 24'sh7FFFFF, -18'sh20000);
      send_item(1'b1, 1'b0, -24'sh800000, -24'sh7FFFF0, -18'sh20000);
      wait_drain();
   endtask

   task automatic test_full_store();
      send_item(1'b0, 1'b1, 24'sd0, 24'sd0, 18'sd0);
      for (int i = 1; i < DEPTH + 3; i++)
         send_item(1'b0, 1'b0, 24'(i * 300), 24'(i * 50), 18'(i));
      send_item(1'b1, 1'b0, 24'sd10, 24'sd10, 18'sd0);
      send_item(1'b1, 1'b0, 24'(255 * 300), 24'(255 * 50), 18'sd255);
      wait_drain();
   endtask

   task automatic test_random(int n_items, int span);
      int path_len;
      int sent;
      longint bx, by;
      logic signed [17:0] hh;
      sent = 0;
      while (sent < n_items) begin
         if ($urandom_range(0, 9) < 8) begin
            path_len = $urandom_range(2, 12);
            bx = $urandom_range(0, 2 * span) - span;
            by = $urandom_range(0, 2 * span) - span;
            for (int i = 0; i < path_len; i++) begin
               send_item(1'b0, i == 0, 24'(bx + i * $urandom_range(0, span / 4)),
                         24'(by + i * ($urandom_range(0, span / 2) - span / 4)),
                         18'($urandom));
               sent++;
            end
            for (int i = 0; i < $urandom_range(3, 10); i++) begin
               hh = 18'($urandom_range(0, 51472) - 25736);
               if ($urandom_range(0, 5) == 0) begin
                  send_item(1'b1, 1'($urandom), 24'(wp_x[wp_count - 1] + $urandom_range(0, 8)),
                            24'(wp_y[wp_count - 1]), 18'(wp_h[wp_count - 1]));
               end else begin
                  send_item(1'b1, 1'($urandom), 24'(bx + $urandom_range(0, span) - span / 2),
                            24'(by + $urandom_range(0, span) - span / 2), hh);
               end
               sent++;
            end
         end else begin
            send_item(1'($urandom), 1'($urandom), rand_pos(span), rand_pos(span),
                      18'($urandom));
            sent++;
         end
      end
      wait_drain();
   endtask

   task automatic test_settings();
      write_reg(ppt_pkg::REG_LOOKAHEAD, 23'h7FFFFF);
      write_reg(ppt_pkg::REG_MIN_SPEED, 15'h7FFF);
      write_reg(ppt_pkg::REG_MAX_SPEED, 15'd100);
      write_reg(ppt_pkg::REG_CURV_GAIN, 16'hFFFF);
      write_reg(ppt_pkg::REG_POS_TOL, 23'h7FFFFF);
      write_reg(ppt_pkg::REG_HEAD_TOL, 16'hFFFF);
      write_reg(REG_UNLISTED, 23'h123);
      test_random(60, 20000);
      write_reg(ppt_pkg::REG_LOOKAHEAD, 0);
      write_reg(ppt_pkg::REG_MIN_SPEED, 0);
      write_reg(ppt_pkg::REG_MAX_SPEED, 15'h7FFF);
      write_reg(ppt_pkg::REG_CURV_GAIN, 0);
      write_reg(ppt_pkg::REG_POS_TOL, 0);
      write_reg(ppt_pkg::REG_HEAD_TOL, 0);
      test_random(60, 20000);
      write_reg(ppt_pkg::REG_LOOKAHEAD, 1024);
      write_reg(ppt_pkg::REG_MIN_SPEED, 2000);
      write_reg(ppt_pkg::REG_MAX_SPEED, 20000);
      write_reg(ppt_pkg::REG_CURV_GAIN, 4000);
      write_reg(ppt_pkg::REG_POS_TOL, 3000);
      write_reg(ppt_pkg::REG_HEAD_TOL, 4000);
      test_random(80, 8000);
   endtask

   initial begin
      req_bus.valid = 1'b0;
      req_bus.req_type = 1'b0;
      req_bus.new_path = 1'b0;
      req_bus.pos_x = '0;
      req_bus.pos_y = '0;
      req_bus.heading = '0;
      r_look = ppt_pkg::RST_LOOKAHEAD;
      r_min = ppt_pkg::RST_MIN_SPEED;
      r_max = ppt_pkg::RST_MAX_SPEED;
      r_gain = ppt_pkg::RST_CURV_GAIN;
      r_ptol = ppt_pkg::RST_POS_TOL;
      r_htol = ppt_pkg::RST_HEAD_TOL;
      wp_count = 0;
      la_index = 0;
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      test_empty_path();
      test_directed();
      burst_mode = 1'b1;
      test_random(170, 10000);
      test_full_store();
      test_settings();
      wait_drain();
      if (fail_count == 0 && expected_drive_q.size() == 0) begin
         $display("Regression PASS");
      end else begin
         if (expected_drive_q.size() != 0) $error("drive results left over");
         $display("Regression FAIL");
      end
      $finish;
   end
endmodule
